// ===== design/cbm_pkg.sv =====
// Shared types and constants for the bank mapper with sound window.
package cbm_pkg;

  localparam int unsigned NumBanks  = 4;
  localparam int unsigned BankW     = 8;
  localparam int unsigned AddrW     = 16;
  localparam int unsigned RomAddrW  = 21;
  localparam int unsigned PageOffW  = 13;

  localparam logic [AddrW-1:0] WinLo      = 16'h9800;
  localparam logic [AddrW-1:0] WinHi      = 16'hA000;
  localparam logic [AddrW-1:0] WrLo       = 16'h5000;
  localparam logic [AddrW-1:0] WrHi       = 16'hC000;
  localparam logic [AddrW-1:0] EnSelMask  = 16'hF800;
  localparam logic [AddrW-1:0] EnSelVal   = 16'h9000;
  localparam logic [AddrW-1:0] BankSelMsk = 16'h1800;
  localparam logic [AddrW-1:0] BankSelVal = 16'h1000;
  localparam logic [5:0]       EnPattern  = 6'h3F;
  localparam logic [BankW-1:0] MaskReset  = 8'hFF;

  typedef enum logic [1:0] {
    TGT_ROM_READ  = 2'd0,
    TGT_SND_READ  = 2'd1,
    TGT_SND_WRITE = 2'd2,
    TGT_NONE      = 2'd3
  } target_e;

  typedef enum logic {
    FUNC_READ  = 1'b0,
    FUNC_WRITE = 1'b1
  } func_e;

  typedef struct packed {
    func_e            func;
    logic [AddrW-1:0] bus_address;
    logic [7:0]       write_value;
  } in_word_t;

  typedef struct packed {
    target_e             target;
    logic [RomAddrW-1:0] rom_address;
    logic [7:0]          sound_offset;
    logic [7:0]          sound_data;
  } out_word_t;

  typedef logic [BankW-1:0] bank_t;

  // mapper state as seen by the decoder
  typedef struct packed {
    bank_t [NumBanks-1:0] banks;
    logic                 win_on;
    bank_t                block_mask;
  } map_state_t;

  // state change requested by one write
  typedef struct packed {
    logic       win_we;
    logic       win_val;
    logic       bank_we;
    logic [1:0] bank_idx;
    bank_t      bank_val;
  } map_upd_t;

endpackage

// ===== design/cartridge_bank_mapper_with_sound_window.sv =====
// Top level: 8 kB bank mapper with sound window, input and result registers.
// An accepted access waits in the input register and moves into the result register once that is free.
// Throughput: one access per cycle while the sink does not stall; the result register frees as the sink takes it.
// State updates land when an access moves into the result register, so the next
// access already decodes against them.
// Reset: banks 0,1,2,3, window off, block mask 0xFF, both stages empty.
module cartridge_bank_mapper_with_sound_window (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cbm_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cbm_pkg::out_word_t out_word_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  cbm_pkg::bank_t     cfg_data_i
);

  logic                in_vld_q;
  cbm_pkg::in_word_t   in_word_q;
  logic                out_vld_q;
  cbm_pkg::out_word_t  out_word_q;
  cbm_pkg::out_word_t  res_d;
  cbm_pkg::map_upd_t   upd;
  cbm_pkg::map_state_t state;
  logic                out_free;
  logic                advance;
  logic                in_take;

  assign out_free = !out_vld_q || !out_stall_i;
  assign advance  = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take  = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  cbm_decode u_decode (
    .word_i  (in_word_q),
    .state_i (state),
    .word_o  (res_d),
    .upd_o   (upd)
  );

  cbm_state u_state (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_en_i   (advance),
    .upd_i      (upd),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .state_o    (state)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_word_q <= in_word_i;
    end
    if (advance) begin
      out_word_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_word_q;

  // window flag only moves when an access is retired into the result stage
  a_win_upd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(state.win_on) |-> $past(advance))
    else $error("window flag changed without a retired access");

  a_bank_upd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(state.banks) |-> $past(advance && upd.bank_we))
    else $error("bank register changed without a bank write");

  a_no_stall_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> !in_stall_o)
    else $error("input stalled with empty result stage");

  a_snd_write_no_upd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_d.target == cbm_pkg::TGT_SND_WRITE) |-> !upd.win_we && !upd.bank_we)
    else $error("sound write also updated mapper state");

endmodule

// ===== design/cbm_decode.sv =====
// Combinational decode of one bus access against the current mapper state.
module cbm_decode (
  input  cbm_pkg::in_word_t   word_i,
  input  cbm_pkg::map_state_t state_i,
  output cbm_pkg::out_word_t  word_o,
  output cbm_pkg::map_upd_t   upd_o
);

  logic       in_win;
  logic       in_wr_range;
  logic [1:0] idx;
  cbm_pkg::bank_t blk;

  assign in_win = state_i.win_on && (word_i.bus_address >= cbm_pkg::WinLo)
                  && (word_i.bus_address < cbm_pkg::WinHi);
  assign in_wr_range = (word_i.bus_address >= cbm_pkg::WrLo)
                       && (word_i.bus_address < cbm_pkg::WrHi);
  // page 2..5 -> bank 0..3; mirrors wrap onto the same banks
  assign idx = word_i.bus_address[14:13] + 2'd2;
  assign blk = state_i.banks[idx] & state_i.block_mask;

  always_comb begin
    word_o = '0;
    word_o.target = cbm_pkg::TGT_NONE;
    upd_o = '0;
    upd_o.bank_idx = idx;
    upd_o.bank_val = word_i.write_value;
    upd_o.win_val  = (word_i.write_value[5:0] == cbm_pkg::EnPattern);
    if (word_i.func == cbm_pkg::FUNC_READ) begin
      if (in_win) begin
        word_o.target       = cbm_pkg::TGT_SND_READ;
        word_o.sound_offset = word_i.bus_address[7:0];
      end else begin
        word_o.target      = cbm_pkg::TGT_ROM_READ;
        word_o.rom_address = {blk, word_i.bus_address[cbm_pkg::PageOffW-1:0]};
      end
    end else if (in_wr_range) begin
      if (in_win) begin
        word_o.target       = cbm_pkg::TGT_SND_WRITE;
        word_o.sound_offset = word_i.bus_address[7:0];
        word_o.sound_data   = word_i.write_value;
      end else begin
        upd_o.win_we  = ((word_i.bus_address & cbm_pkg::EnSelMask) == cbm_pkg::EnSelVal);
        upd_o.bank_we = ((word_i.bus_address & cbm_pkg::BankSelMsk) == cbm_pkg::BankSelVal);
      end
    end
  end

endmodule

// ===== design/cbm_state.sv =====
// Bank registers, sound window flag and block mask register.
module cbm_state (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                upd_en_i,
  input  cbm_pkg::map_upd_t   upd_i,
  input  logic                cfg_we_i,
  input  cbm_pkg::bank_t      cfg_data_i,
  output cbm_pkg::map_state_t state_o
);

  cbm_pkg::bank_t [cbm_pkg::NumBanks-1:0] banks_q;
  logic           win_q;
  cbm_pkg::bank_t mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < cbm_pkg::NumBanks; i++) begin
        banks_q[i] <= cbm_pkg::bank_t'(i);
      end
      win_q  <= 1'b0;
      mask_q <= cbm_pkg::MaskReset;
    end else begin
      if (upd_en_i && upd_i.bank_we) begin
        banks_q[upd_i.bank_idx] <= upd_i.bank_val;
      end
      if (upd_en_i && upd_i.win_we) begin
        win_q <= upd_i.win_val;
      end
      if (cfg_we_i) begin
        mask_q <= cfg_data_i;
      end
    end
  end

  assign state_o.banks      = banks_q;
  assign state_o.win_on     = win_q;
  assign state_o.block_mask = mask_q;

endmodule
